// File: hw/rtl/h2b_pkg.sv
// Shared types, status codes and character helpers for the hex to base64 encoder.
`default_nettype none

package h2b_pkg;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
   localparam logic [1:0] STATUS_ODD_LEN  = 2'd2;

   localparam logic [7:0] PAD_CHAR = 8'd61;   // '='

   typedef enum logic {
      JOB_GROUP,
      JOB_ERROR
   } job_kind_type;

   // One unit of work for the back end: either a 3-byte group to emit as
   // four characters (the last pad_count of them as '='), or one error result.
   typedef struct packed {
      job_kind_type kind;
      logic [23:0]  group;
      logic [1:0]   pad_count;
      logic [1:0]   status;
      logic         eos;
   } job_type;

   // Returns {invalid, nibble}.
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] res;
      res = 5'b10000;
      if (c >= 8'd48 && c <= 8'd57) begin
         res = {1'b0, c[3:0]};
      end else if ((c >= 8'd97 && c <= 8'd102) || (c >= 8'd65 && c <= 8'd70)) begin
         res = {1'b0, 4'(c[3:0] + 4'd9)};
      end
      return res;
   endfunction

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] res;
      if (v < 6'd26) begin
         res = 8'd65 + {2'b00, v};
      end else if (v < 6'd52) begin
         res = 8'd71 + {2'b00, v};
      end else if (v < 6'd62) begin
         res = {2'b00, v} - 8'd4;
      end else if (v == 6'd62) begin
         res = 8'd43;
      end else begin
         res = 8'd47;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/h2b_front.sv
// Front end: takes hex characters, assembles bytes and groups, queues work for the back end.
`default_nettype none

module h2b_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [7:0]       req_tdata,   // [7:0] hex_char
   input  wire logic             req_tlast,
   input  wire logic             req_tvalid,
   output      logic             req_tready,
   input  wire logic             queue_full,
   output      logic             job_push,
   output      h2b_pkg::job_type job_data
);
   import h2b_pkg::*;

   logic [3:0]  held_nibble_ff, held_nibble_in;
   logic        pending_ff, pending_in;
   logic [15:0] group_bytes_ff, group_bytes_in;
   logic [1:0]  count_ff, count_in;
   logic        bad_ff, bad_in;

   logic        accept;
   logic [4:0]  decoded;
   logic [7:0]  new_byte;
   logic        emit_group;
   logic        parity_after;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign decoded    = hex_decode(req_tdata);
   assign new_byte   = {held_nibble_ff, decoded[3:0]};
   assign parity_after = !pending_ff;

   always_comb begin
      held_nibble_in = held_nibble_ff;
      group_bytes_in = group_bytes_ff;
      count_in       = count_ff;
      bad_in         = bad_ff;
      pending_in     = parity_after;
      emit_group     = 1'b0;
      job_push       = 1'b0;
      job_data.kind      = JOB_GROUP;
      job_data.group     = {group_bytes_ff, new_byte};
      job_data.pad_count = 2'd0;
      job_data.status    = STATUS_OK;
      job_data.eos       = 1'b0;

      if (!bad_ff) begin
         if (decoded[4]) begin
            bad_in = 1'b1;
         end else if (pending_ff) begin
            if (count_ff >= 2'd2) begin
               emit_group = 1'b1;
               count_in   = 2'd0;
            end else begin
               group_bytes_in = {group_bytes_ff[7:0], new_byte};
               count_in       = 2'(count_ff + 2'd1);
            end
         end else begin
            held_nibble_in = decoded[3:0];
         end
      end
      job_push = emit_group;

      if (req_tlast) begin
         // an odd count wins over an earlier bad character
         if (parity_after) begin
            job_push        = 1'b1;
            job_data.kind   = JOB_ERROR;
            job_data.status = STATUS_ODD_LEN;
            job_data.eos    = 1'b1;
         end else if (bad_in) begin
            job_push        = 1'b1;
            job_data.kind   = JOB_ERROR;
            job_data.status = STATUS_BAD_CHAR;
            job_data.eos    = 1'b1;
         end else if (count_in == 2'd1) begin
            job_push           = 1'b1;
            job_data.group     = {group_bytes_in[7:0], 16'd0};
            job_data.pad_count = 2'd2;
            job_data.eos       = 1'b1;
         end else if (count_in == 2'd2) begin
            job_push           = 1'b1;
            job_data.group     = {group_bytes_in, 8'd0};
            job_data.pad_count = 2'd1;
            job_data.eos       = 1'b1;
         end else begin
            job_data.eos = 1'b1;
         end
         held_nibble_in = 4'd0;
         pending_in     = 1'b0;
         count_in       = 2'd0;
         bad_in         = 1'b0;
      end
      job_push = job_push && accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_nibble_ff <= 4'd0;
         pending_ff     <= 1'b0;
         count_ff       <= 2'd0;
         bad_ff         <= 1'b0;
      end else if (accept) begin
         held_nibble_ff <= held_nibble_in;
         pending_ff     <= pending_in;
         count_ff       <= count_in;
         bad_ff         <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         group_bytes_ff <= group_bytes_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/h2b_fifo.sv
// Small job queue between the front and back ends.
`default_nettype none

module h2b_fifo #(
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire h2b_pkg::job_type push_data,
   input  wire logic             pop,
   output      logic             full,
   output      logic             empty,
   output      h2b_pkg::job_type head
);
   import h2b_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type        entries_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/h2b_back.sv
// Back end: jobs to base64 characters, one per cycle unless stalled, through an output register.
`default_nettype none

module h2b_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_empty,
   input  wire h2b_pkg::job_type job_head,
   output      logic             job_pop,
   output      logic [7:0]       rsp_tdata,   // [7:0] out_char
   output      logic [1:0]       rsp_tuser,   // [1:0] status
   output      logic             rsp_tlast,
   output      logic             rsp_tvalid,
   input  wire logic             rsp_tready
);
   import h2b_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff;
   logic [7:0] char_ff, char_in;
   logic [1:0] status_ff, status_in;
   logic       last_ff, last_in;
   logic       load;
   logic       produce;
   logic [5:0] sextet;

   assign load    = !valid_ff || rsp_tready;
   assign produce = load && !job_empty;

   always_comb begin
      unique case (idx_ff)
         2'd0: sextet = job_head.group[23:18];
         2'd1: sextet = job_head.group[17:12];
         2'd2: sextet = job_head.group[11:6];
         2'd3: sextet = job_head.group[5:0];
         default: sextet = job_head.group[5:0];
      endcase
   end

   always_comb begin
      char_in   = b64_char(sextet);
      status_in = STATUS_OK;
      last_in   = 1'b0;
      idx_in    = 2'(idx_ff + 2'd1);
      job_pop   = 1'b0;
      unique case (job_head.kind)
         JOB_ERROR: begin
            char_in   = 8'd0;
            status_in = job_head.status;
            last_in   = 1'b1;
            idx_in    = 2'd0;
            job_pop   = produce;
         end
         JOB_GROUP: begin
            // trailing characters of a short final group are padding
            if (3'({1'b0, idx_ff}) + 3'({1'b0, job_head.pad_count}) > 3'd3) begin
               char_in = PAD_CHAR;
            end
            if (idx_ff == 2'd3) begin
               last_in = job_head.eos;
               idx_in  = 2'd0;
               job_pop = produce;
            end
         end
         default: begin
            job_pop = produce;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= !job_empty;
         if (produce) begin
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         char_ff   <= char_in;
         status_ff <= status_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// File: hw/rtl/hex_to_base64_stream.sv
// Top level of the hex to base64 stream encoder.
// Encodes a string of ASCII hex digits (either case, tlast on the final one) into standard
// base64 with '=' padding. One character is accepted per cycle while the job queue has room;
// every third completed byte queues a 4-character group, which the output stage sends at one
// character per cycle while rsp_tready is high, so six hex digits in match four characters out
// and a steady input stream runs at one item per cycle while the output is not stalled. The
// first result of a job passes through the job queue and then the output register after the
// completing input is accepted. A string with an odd length or a non-hex character ends with
// a single result whose tuser carries the error status (odd length wins), tdata 0 and tlast
// set; groups sent earlier in that string stand. Every string ends with a result that has
// tlast set.
`default_nettype none

module hex_to_base64_stream #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] req_tdata,   // [7:0] hex_char
   input  wire logic       req_tlast,   // is_last
   input  wire logic       req_tvalid,
   output      logic       req_tready,
   output      logic [7:0] rsp_tdata,   // [7:0] out_char
   output      logic [1:0] rsp_tuser,   // [1:0] status
   output      logic       rsp_tlast,   // end_of_string
   output      logic       rsp_tvalid,
   input  wire logic       rsp_tready
);
   import h2b_pkg::*;

   logic    queue_full;
   logic    queue_empty;
   logic    job_push;
   logic    job_pop;
   job_type job_in;
   job_type job_head;

   h2b_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .queue_full (queue_full),
      .job_push   (job_push),
      .job_data   (job_in)
   );

   h2b_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .pop       (job_pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .head      (job_head)
   );

   h2b_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_empty  (queue_empty),
      .job_head   (job_head),
      .job_pop    (job_pop),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

endmodule

`default_nettype wire

// File: hw/rtl/h2b_checker.sv
// Port-level checks for the hex to base64 encoder, bound to the top level.
`default_nettype none

module h2b_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic [7:0] rsp_tdata,
   input wire logic [1:0] rsp_tuser,
   input wire logic       rsp_tlast,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready
);
   import h2b_pkg::*;

   // a stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   // error results carry no character and close the string
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata == 8'd0 && rsp_tlast)
      else $error("malformed error result");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == STATUS_OK || rsp_tuser == STATUS_BAD_CHAR
         || rsp_tuser == STATUS_ODD_LEN)
      else $error("unknown status code");

endmodule

bind hex_to_base64_stream h2b_checker u_h2b_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire
